>>> design/dcf77_pulse_receiver_unit_assert.svh
// Assertion macros for the pulse receiver unit.
// DCF_ASSERT checks a property on every rising clock edge outside reset.
// DCF_ASSERT_NEXT checks that an antecedent is followed by a consequent
// in the next cycle.
`ifndef DCF77_PULSE_RECEIVER_UNIT_ASSERT_SVH
`define DCF77_PULSE_RECEIVER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define DCF_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dcf77 receiver assertion failed");
`define DCF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcf77 receiver assertion failed");
`else
`define DCF_ASSERT(name, prop)
`define DCF_ASSERT_NEXT(name, ante, cons)
`endif
`endif

>>> design/dcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dcf_pkg;

  localparam int FRAME_BITS    = 59;
  localparam int COUNTER_WIDTH = 16;
  localparam int CFG_W         = 16;
  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_W     = $clog2(NUM_REGS);
  localparam int BIT_IDX_W     = $clog2(FRAME_BITS + 1);
  localparam int FAIL_W        = 8;
  localparam int CMP_W         = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MAX  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MAX = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX  = CFG_IDX_W'(7);

  // Register reset values, in ticks
  localparam logic [CFG_W-1:0] GAP_MIN_RST  = CFG_W'(9600);
  localparam logic [CFG_W-1:0] GAP_MAX_RST  = CFG_W'(12160);
  localparam logic [CFG_W-1:0] SYNC_MIN_RST = CFG_W'(21760);
  localparam logic [CFG_W-1:0] SYNC_MAX_RST = CFG_W'(24960);
  localparam logic [CFG_W-1:0] ZERO_MIN_RST = CFG_W'(896);
  localparam logic [CFG_W-1:0] ZERO_MAX_RST = CFG_W'(1664);
  localparam logic [CFG_W-1:0] ONE_MIN_RST  = CFG_W'(2176);
  localparam logic [CFG_W-1:0] ONE_MAX_RST  = CFG_W'(2944);

  typedef struct packed {
    logic [CFG_W-1:0] gap_min;
    logic [CFG_W-1:0] gap_max;
    logic [CFG_W-1:0] sync_min;
    logic [CFG_W-1:0] sync_max;
    logic [CFG_W-1:0] zero_min;
    logic [CFG_W-1:0] zero_max;
    logic [CFG_W-1:0] one_min;
    logic [CFG_W-1:0] one_max;
  } cfg_t;

  typedef struct packed {
    logic                  frame_done;
    logic [FRAME_BITS-1:0] frame_data;
    logic                  fail_event;
    logic                  synchronized;
    logic [BIT_IDX_W-1:0]  bits_received;
    logic [FAIL_W-1:0]     fail_total;
  } result_t;

  // True when a tick count lies in [lo, hi]; an inverted window matches nothing
  function automatic logic in_window(input logic [COUNTER_WIDTH-1:0] v,
                                     input logic [CFG_W-1:0] lo,
                                     input logic [CFG_W-1:0] hi);
    logic [CMP_W-1:0] ve;
    logic [CMP_W-1:0] loe;
    logic [CMP_W-1:0] hie;
    ve  = CMP_W'(v);
    loe = CMP_W'(lo);
    hie = CMP_W'(hi);
    return (ve >= loe) && (ve <= hie);
  endfunction

endpackage
`default_nettype wire

>>> design/dcf_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module dcf_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [dcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dcf_pkg::CFG_W-1:0]     cfg_data,
  output dcf_pkg::cfg_t                      cfg
);

  // Load reset thresholds, then take writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_min  <= dcf_pkg::GAP_MIN_RST;
      cfg.gap_max  <= dcf_pkg::GAP_MAX_RST;
      cfg.sync_min <= dcf_pkg::SYNC_MIN_RST;
      cfg.sync_max <= dcf_pkg::SYNC_MAX_RST;
      cfg.zero_min <= dcf_pkg::ZERO_MIN_RST;
      cfg.zero_max <= dcf_pkg::ZERO_MAX_RST;
      cfg.one_min  <= dcf_pkg::ONE_MIN_RST;
      cfg.one_max  <= dcf_pkg::ONE_MAX_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dcf_pkg::REG_GAP_MIN:  cfg.gap_min  <= cfg_data;
        dcf_pkg::REG_GAP_MAX:  cfg.gap_max  <= cfg_data;
        dcf_pkg::REG_SYNC_MIN: cfg.sync_min <= cfg_data;
        dcf_pkg::REG_SYNC_MAX: cfg.sync_max <= cfg_data;
        dcf_pkg::REG_ZERO_MIN: cfg.zero_min <= cfg_data;
        dcf_pkg::REG_ZERO_MAX: cfg.zero_max <= cfg_data;
        dcf_pkg::REG_ONE_MIN:  cfg.one_min  <= cfg_data;
        dcf_pkg::REG_ONE_MAX:  cfg.one_max  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/dcf_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "dcf77_pulse_receiver_unit_assert.svh"
module dcf_core (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  wire logic    level,
  input  wire logic    restart,
  input  wire logic    clear_fails,
  input  wire dcf_pkg::cfg_t cfg,
  output dcf_pkg::result_t res
);

  logic                                 prev_level, prev_level_next;
  logic                                 await_rising, await_rising_next;
  logic [dcf_pkg::COUNTER_WIDTH-1:0]    tick_count, tick_count_next;
  logic                                 sync_flag, sync_flag_next;
  logic [dcf_pkg::BIT_IDX_W-1:0]        bit_index, bit_index_next;
  logic [dcf_pkg::FRAME_BITS-1:0]       shift_frame, shift_frame_next;
  logic [dcf_pkg::FRAME_BITS-1:0]       held_frame, held_frame_next;
  logic [dcf_pkg::FAIL_W-1:0]           fault_count, fault_count_next;

  logic                                 rising, falling;
  logic                                 in_gap, in_sync, in_zero, in_one;
  logic                                 bad_pulse, still_synced;
  logic [dcf_pkg::FAIL_W-1:0]           fault_base;
  logic [dcf_pkg::COUNTER_WIDTH-1:0]    tick_inc;
  logic [dcf_pkg::BIT_IDX_W-1:0]        index_inc;
  logic [dcf_pkg::FRAME_BITS-1:0]       bit_mask;
  logic                                 done, fail;

  // Window compares on the count before this tick
  assign in_gap  = dcf_pkg::in_window(tick_count, cfg.gap_min, cfg.gap_max);
  assign in_sync = dcf_pkg::in_window(tick_count, cfg.sync_min, cfg.sync_max);
  assign in_zero = dcf_pkg::in_window(tick_count, cfg.zero_min, cfg.zero_max);
  assign in_one  = dcf_pkg::in_window(tick_count, cfg.one_min, cfg.one_max);

  assign rising    = !prev_level && level;
  assign falling   = prev_level && !level;
  assign tick_inc  = tick_count + dcf_pkg::COUNTER_WIDTH'(1);
  assign index_inc = bit_index + dcf_pkg::BIT_IDX_W'(1);
  assign bit_mask  = dcf_pkg::FRAME_BITS'(1) << bit_index;
  assign bad_pulse = !in_zero && !in_one;
  assign fault_base = clear_fails ? '0 : fault_count;

  // Decide the next state for one sample
  always_comb begin
    prev_level_next   = level;
    await_rising_next = await_rising;
    tick_count_next   = tick_count;
    sync_flag_next    = sync_flag;
    bit_index_next    = bit_index;
    shift_frame_next  = shift_frame;
    held_frame_next   = held_frame;
    fault_count_next  = fault_count;
    still_synced      = sync_flag;
    done              = 1'b0;
    fail              = 1'b0;
    if (restart) begin
      sync_flag_next    = 1'b0;
      bit_index_next    = '0;
      shift_frame_next  = '0;
      fault_count_next  = '0;
      tick_count_next   = '0;
      await_rising_next = 1'b1;
    end else begin
      fault_count_next = fault_base;
      if (await_rising && rising) begin
        // End of a low gap
        if (sync_flag) begin
          if (!in_gap) begin
            sync_flag_next   = 1'b0;
            fault_count_next = fault_base + dcf_pkg::FAIL_W'(1);
            fail             = 1'b1;
          end
        end else if (in_sync) begin
          sync_flag_next   = 1'b1;
          bit_index_next   = '0;
          shift_frame_next = '0;
        end
        tick_count_next   = '0;
        await_rising_next = 1'b0;
      end else if (!await_rising && falling) begin
        // End of a high pulse: class it as a bit
        if (!in_zero && in_one &&
            (bit_index < dcf_pkg::BIT_IDX_W'(dcf_pkg::FRAME_BITS))) begin
          shift_frame_next = shift_frame | bit_mask;
        end
        if (bad_pulse) begin
          fail             = sync_flag;
          still_synced     = 1'b0;
          sync_flag_next   = 1'b0;
          fault_count_next = fault_base + dcf_pkg::FAIL_W'(1);
        end
        if (still_synced) begin
          bit_index_next = index_inc;
          if (index_inc >= dcf_pkg::BIT_IDX_W'(dcf_pkg::FRAME_BITS)) begin
            sync_flag_next  = 1'b0;
            held_frame_next = shift_frame_next;
            done            = 1'b1;
          end
        end
        tick_count_next   = '0;
        await_rising_next = 1'b1;
      end else begin
        // No edge acted on: count, a wrap is a timeout
        tick_count_next = tick_inc;
        if (tick_inc == '0) begin
          fault_count_next = fault_base + dcf_pkg::FAIL_W'(1);
          sync_flag_next   = 1'b0;
        end
      end
    end
  end

  // Result of this sample
  always_comb begin
    res.frame_done    = done;
    res.frame_data    = held_frame_next;
    res.fail_event    = fail;
    res.synchronized  = sync_flag_next;
    res.bits_received = bit_index_next;
    res.fail_total    = fault_count_next;
  end

  // Hold control state; advance on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level   <= 1'b0;
      await_rising <= 1'b1;
      tick_count   <= '0;
      sync_flag    <= 1'b0;
      bit_index    <= '0;
      shift_frame  <= '0;
      held_frame   <= '0;
      fault_count  <= '0;
    end else if (step) begin
      prev_level   <= prev_level_next;
      await_rising <= await_rising_next;
      tick_count   <= tick_count_next;
      sync_flag    <= sync_flag_next;
      bit_index    <= bit_index_next;
      shift_frame  <= shift_frame_next;
      held_frame   <= held_frame_next;
      fault_count  <= fault_count_next;
    end
  end

  `DCF_ASSERT(a_sync_index_in_frame,
              sync_flag |-> (bit_index < dcf_pkg::BIT_IDX_W'(dcf_pkg::FRAME_BITS)))
  `DCF_ASSERT(a_done_needs_sync, (step && done) |-> (sync_flag && !restart))

endmodule
`default_nettype wire

>>> design/dcf77_pulse_receiver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "dcf77_pulse_receiver_unit_assert.svh"
// Pulse receiver for the demodulated DCF77 time signal.
// Input channel (in_valid / in_stall): one beat per time-base tick carrying
// the sampled level plus the restart and clear_fails controls.
// Output channel (out_valid / out_stall): one beat per input beat with the
// frame flag, the last completed frame, the fail flag, sync status, bit
// position and fault total after that tick.
// Configuration: eight 16-bit tick thresholds written through cfg_write,
// cfg_index and cfg_data; write them only while no beat is in flight.
// Path: each input beat passes the input register, then the decision logic
// into the result register.
// Throughput: one beat per cycle while the result side does not stall; the
// decode core updates its state once per accepted beat.
// Reset: synchronous rst empties both registers, loads the default
// thresholds and clears the receiver state to await a rising edge.
// When out_stall is held the result waits in its register, the input
// register holds its beat and in_stall rises; no beat is lost.
module dcf77_pulse_receiver_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [dcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dcf_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               signal_level,
  input  wire logic                               restart,
  input  wire logic                               clear_fails,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    frame_done,
  output logic [dcf_pkg::FRAME_BITS-1:0]          frame_data,
  output logic                                    fail_event,
  output logic                                    synchronized,
  output logic [dcf_pkg::BIT_IDX_W-1:0]           bits_received,
  output logic [dcf_pkg::FAIL_W-1:0]              fail_total
);

  dcf_pkg::cfg_t    cfg;
  dcf_pkg::result_t res;
  dcf_pkg::result_t res_reg;

  logic in_reg_valid;
  logic in_level, in_restart, in_clear;
  logic advance, step;

  dcf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcf_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .level       (in_level),
    .restart     (in_restart),
    .clear_fails (in_clear),
    .cfg         (cfg),
    .res         (res)
  );

  // Result register is free or being taken this cycle
  assign advance  = !out_valid || !out_stall;
  assign step     = in_reg_valid && advance;
  assign in_stall = in_reg_valid && !advance;

  // Input register: take a beat unless holding one that cannot move
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_level   <= signal_level;
      in_restart <= restart;
      in_clear   <= clear_fails;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_reg <= res;
    end
  end

  assign frame_done    = res_reg.frame_done;
  assign frame_data    = res_reg.frame_data;
  assign fail_event    = res_reg.fail_event;
  assign synchronized  = res_reg.synchronized;
  assign bits_received = res_reg.bits_received;
  assign fail_total    = res_reg.fail_total;

  `DCF_ASSERT_NEXT(a_step_gives_result, step, out_valid)
  `DCF_ASSERT(a_fail_drops_sync, (out_valid && fail_event) |-> !synchronized)

endmodule
`default_nettype wire

>>> tb/dcf77_pulse_receiver_unit_tb.sv
`timescale 1ns / 1ps

// Tracks the receiver state tick by tick and holds the outcome of every
// accepted tick until the matching result beat arrives.
class tick_scoreboard;
  logic [dcf_pkg::CFG_W-1:0]         thr [dcf_pkg::NUM_REGS];
  logic                              prev_lvl;
  logic                              awaiting_rise;
  logic [dcf_pkg::COUNTER_WIDTH-1:0] tick_cnt;
  logic                              in_sync;
  logic [dcf_pkg::BIT_IDX_W-1:0]     bit_pos;
  logic [dcf_pkg::FRAME_BITS-1:0]    shifted;
  logic [dcf_pkg::FRAME_BITS-1:0]    latched;
  logic [dcf_pkg::FAIL_W-1:0]        faults;
  dcf_pkg::result_t                  tick_outcomes[$];
  int                                errors;

  function new();
    thr[dcf_pkg::REG_GAP_MIN]  = dcf_pkg::GAP_MIN_RST;
    thr[dcf_pkg::REG_GAP_MAX]  = dcf_pkg::GAP_MAX_RST;
    thr[dcf_pkg::REG_SYNC_MIN] = dcf_pkg::SYNC_MIN_RST;
    thr[dcf_pkg::REG_SYNC_MAX] = dcf_pkg::SYNC_MAX_RST;
    thr[dcf_pkg::REG_ZERO_MIN] = dcf_pkg::ZERO_MIN_RST;
    thr[dcf_pkg::REG_ZERO_MAX] = dcf_pkg::ZERO_MAX_RST;
    thr[dcf_pkg::REG_ONE_MIN]  = dcf_pkg::ONE_MIN_RST;
    thr[dcf_pkg::REG_ONE_MAX]  = dcf_pkg::ONE_MAX_RST;
    prev_lvl      = 1'b0;
    awaiting_rise = 1'b1;
    tick_cnt      = '0;
    in_sync       = 1'b0;
    bit_pos       = '0;
    shifted       = '0;
    latched       = '0;
    faults        = '0;
    errors        = 0;
  endfunction

  function void set_threshold(input logic [dcf_pkg::CFG_IDX_W-1:0] idx,
                              input logic [dcf_pkg::CFG_W-1:0] val);
    thr[idx] = val;
  endfunction

  // An inverted window (min above max) never matches
  function bit in_range(input logic [dcf_pkg::COUNTER_WIDTH-1:0] v,
                        input logic [dcf_pkg::CFG_IDX_W-1:0] lo_reg,
                        input logic [dcf_pkg::CFG_IDX_W-1:0] hi_reg);
    return (v >= thr[lo_reg]) && (v <= thr[hi_reg]);
  endfunction

  // Advance the receiver by one accepted input beat and queue its outcome
  function void take_sample(input logic lv, input logic rs, input logic cf);
    dcf_pkg::result_t                  r;
    logic [dcf_pkg::COUNTER_WIDTH-1:0] cnt;
    logic                              rising;
    logic                              falling;
    logic                              done;
    logic                              fail;
    done = 1'b0;
    fail = 1'b0;
    if (rs) begin
      // restart beats everything, keeps the latched frame
      in_sync       = 1'b0;
      bit_pos       = '0;
      shifted       = '0;
      faults        = '0;
      tick_cnt      = '0;
      awaiting_rise = 1'b1;
      prev_lvl      = lv;
    end else begin
      rising  = !prev_lvl && lv;
      falling = prev_lvl && !lv;
      cnt     = tick_cnt;
      if (cf) faults = '0;
      if (awaiting_rise && rising) begin
        // end of a low gap
        if (in_sync) begin
          if (!in_range(cnt, dcf_pkg::REG_GAP_MIN, dcf_pkg::REG_GAP_MAX)) begin
            in_sync = 1'b0;
            faults  = faults + dcf_pkg::FAIL_W'(1);
            fail    = 1'b1;
          end
        end else if (in_range(cnt, dcf_pkg::REG_SYNC_MIN, dcf_pkg::REG_SYNC_MAX)) begin
          in_sync = 1'b1;
          bit_pos = '0;
          shifted = '0;
        end
        tick_cnt      = '0;
        awaiting_rise = 1'b0;
      end else if (!awaiting_rise && falling) begin
        // end of a high pulse: zero window takes priority over one window
        if (in_range(cnt, dcf_pkg::REG_ZERO_MIN, dcf_pkg::REG_ZERO_MAX)) begin
        end else if (in_range(cnt, dcf_pkg::REG_ONE_MIN, dcf_pkg::REG_ONE_MAX)) begin
          if (bit_pos < dcf_pkg::BIT_IDX_W'(dcf_pkg::FRAME_BITS)) shifted[bit_pos] = 1'b1;
        end else begin
          fail    = in_sync;
          in_sync = 1'b0;
          faults  = faults + dcf_pkg::FAIL_W'(1);
        end
        if (in_sync) begin
          bit_pos = bit_pos + dcf_pkg::BIT_IDX_W'(1);
          if (bit_pos >= dcf_pkg::BIT_IDX_W'(dcf_pkg::FRAME_BITS)) begin
            in_sync = 1'b0;
            latched = shifted;
            done    = 1'b1;
          end
        end
        tick_cnt      = '0;
        awaiting_rise = 1'b1;
      end else begin
        // no edge acted on: count, a wrap is a timeout fault
        tick_cnt = tick_cnt + dcf_pkg::COUNTER_WIDTH'(1);
        if (tick_cnt == '0) begin
          faults  = faults + dcf_pkg::FAIL_W'(1);
          in_sync = 1'b0;
        end
      end
      prev_lvl = lv;
    end
    r.frame_done    = done;
    r.frame_data    = latched;
    r.fail_event    = fail;
    r.synchronized  = in_sync;
    r.bits_received = bit_pos;
    r.fail_total    = faults;
    tick_outcomes.push_back(r);
  endfunction

  function void flag(input string field, input logic [63:0] want, input logic [63:0] got);
    errors++;
    if (errors <= 200) $error("%s: expected %0h, got %0h", field, want, got);
  endfunction

  // Compare a result beat against the oldest pending tick outcome
  function void compare_tick(input dcf_pkg::result_t got);
    dcf_pkg::result_t want;
    if (tick_outcomes.size() == 0) begin
      errors++;
      if (errors <= 200) $error("result beat with no tick awaiting it");
      return;
    end
    want = tick_outcomes.pop_front();
    if (got.frame_done !== want.frame_done)
      flag("frame_done", 64'(want.frame_done), 64'(got.frame_done));
    if (got.frame_data !== want.frame_data)
      flag("frame_data", 64'(want.frame_data), 64'(got.frame_data));
    if (got.fail_event !== want.fail_event)
      flag("fail_event", 64'(want.fail_event), 64'(got.fail_event));
    if (got.synchronized !== want.synchronized)
      flag("synchronized", 64'(want.synchronized), 64'(got.synchronized));
    if (got.bits_received !== want.bits_received)
      flag("bits_received", 64'(want.bits_received), 64'(got.bits_received));
    if (got.fail_total !== want.fail_total)
      flag("fail_total", 64'(want.fail_total), 64'(got.fail_total));
  endfunction
endclass

module dcf77_pulse_receiver_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 120;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [dcf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dcf_pkg::CFG_W-1:0]      cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           signal_level = 1'b0;
  logic                           restart = 1'b0;
  logic                           clear_fails = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           frame_done;
  logic [dcf_pkg::FRAME_BITS-1:0] frame_data;
  logic                           fail_event;
  logic                           synchronized;
  logic [dcf_pkg::BIT_IDX_W-1:0]  bits_received;
  logic [dcf_pkg::FAIL_W-1:0]     fail_total;

  tick_scoreboard sb;
  bit             no_idle = 1'b0;
  bit             hold_request = 1'b0;
  int unsigned    sent = 0;
  int unsigned    cycle_count = 0;

  dcf77_pulse_receiver_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .signal_level  (signal_level),
    .restart       (restart),
    .clear_fails   (clear_fails),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_done    (frame_done),
    .frame_data    (frame_data),
    .fail_event    (fail_event),
    .synchronized  (synchronized),
    .bits_received (bits_received),
    .fail_total    (fail_total)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up if the run hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[dcf77_pulse_receiver_unit] ERROR");
    $finish;
  end

  // Note accepted input beats, check accepted result beats
  always @(posedge clk) begin
    dcf_pkg::result_t seen;
    if (!rst) begin
      if (in_valid && !in_stall) sb.take_sample(signal_level, restart, clear_fails);
      if (out_valid && !out_stall) begin
        seen.frame_done    = frame_done;
        seen.frame_data    = frame_data;
        seen.fail_event    = fail_event;
        seen.synchronized  = synchronized;
        seen.bits_received = bits_received;
        seen.fail_total    = fail_total;
        sb.compare_tick(seen);
      end
    end
  end

  // Result side: random stall after each beat, one long hold on request
  initial begin
    int unsigned stall_left;
    int unsigned n;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        stall_left = 0;
      end else if (out_valid && !out_stall) begin
        n = no_idle ? 0 : $urandom_range(0, 5);
        out_stall <= (n != 0);
        stall_left = (n == 0) ? 0 : n - 1;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one sample beat after a random gap and hold it until accepted
  task automatic send_sample(input logic lv, input logic rs, input logic cf);
    int unsigned idle;
    idle = no_idle ? 0 : $urandom_range(0, 5);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid     <= 1'b1;
    signal_level <= lv;
    restart      <= rs;
    clear_fails  <= cf;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_run(input logic lv, input int unsigned n);
    repeat (n) send_sample(lv, 1'b0, $urandom_range(0, 39) == 0);
  endtask

  // Samples for a level run whose measured count falls in [lo, hi]
  function automatic int unsigned run_len(input logic [dcf_pkg::CFG_W-1:0] lo,
                                          input logic [dcf_pkg::CFG_W-1:0] hi);
    int unsigned span;
    if (lo > hi) return $urandom_range(1, 4);
    span = 32'(hi - lo);
    if (span > 3) span = 3;
    return 32'(lo) + $urandom_range(0, span) + 1;
  endfunction

  // Minute marker then 59 bits of random content, sometimes broken once
  task automatic send_frame();
    int          bad_bit;
    logic        bad_gap;
    logic        one_bit;
    int unsigned len;
    bad_bit = ($urandom_range(0, 3) == 0) ?
              int'($urandom_range(0, dcf_pkg::FRAME_BITS - 1)) : -1;
    bad_gap = 1'($urandom_range(0, 1));
    send_run(1'b0, 1);
    send_run(1'b1, 2);
    send_run(1'b0, run_len(sb.thr[dcf_pkg::REG_SYNC_MIN], sb.thr[dcf_pkg::REG_SYNC_MAX]));
    for (int b = 0; b < dcf_pkg::FRAME_BITS; b++) begin
      one_bit = 1'($urandom_range(0, 1));
      if (sb.thr[dcf_pkg::REG_ZERO_MIN] > sb.thr[dcf_pkg::REG_ZERO_MAX]) one_bit = 1'b1;
      else if (sb.thr[dcf_pkg::REG_ONE_MIN] > sb.thr[dcf_pkg::REG_ONE_MAX]) one_bit = 1'b0;
      len = one_bit ? run_len(sb.thr[dcf_pkg::REG_ONE_MIN], sb.thr[dcf_pkg::REG_ONE_MAX])
                    : run_len(sb.thr[dcf_pkg::REG_ZERO_MIN], sb.thr[dcf_pkg::REG_ZERO_MAX]);
      if (b == bad_bit && !bad_gap) len = $urandom_range(1, 12);
      send_run(1'b1, len);
      if (b == dcf_pkg::FRAME_BITS - 1) begin
        send_run(1'b0, 1);
      end else begin
        len = run_len(sb.thr[dcf_pkg::REG_GAP_MIN], sb.thr[dcf_pkg::REG_GAP_MAX]);
        if (b == bad_bit && bad_gap) len = $urandom_range(1, 12);
        send_run(1'b0, len);
      end
      if (b == bad_bit) break;
    end
  endtask

  // Random levels with restarts and fail clears mixed in
  task automatic send_noise();
    int unsigned n;
    logic        lv;
    n  = $urandom_range(10, 30);
    lv = 1'($urandom_range(0, 1));
    repeat (n) begin
      if ($urandom_range(0, 1) != 0) lv = ~lv;
      send_sample(lv, $urandom_range(0, 24) == 0, $urandom_range(0, 7) == 0);
    end
  endtask

  // Drop valid and wait until every pending result has been checked
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.tick_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dcf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dcf_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_threshold(idx, val);
  endtask

  task automatic load_thresholds(input logic [dcf_pkg::CFG_W-1:0] gl,
                                 input logic [dcf_pkg::CFG_W-1:0] gh,
                                 input logic [dcf_pkg::CFG_W-1:0] sl,
                                 input logic [dcf_pkg::CFG_W-1:0] sh,
                                 input logic [dcf_pkg::CFG_W-1:0] zl,
                                 input logic [dcf_pkg::CFG_W-1:0] zh,
                                 input logic [dcf_pkg::CFG_W-1:0] ol,
                                 input logic [dcf_pkg::CFG_W-1:0] oh);
    settle();
    write_reg(dcf_pkg::REG_GAP_MIN, gl);
    write_reg(dcf_pkg::REG_GAP_MAX, gh);
    write_reg(dcf_pkg::REG_SYNC_MIN, sl);
    write_reg(dcf_pkg::REG_SYNC_MAX, sh);
    write_reg(dcf_pkg::REG_ZERO_MIN, zl);
    write_reg(dcf_pkg::REG_ZERO_MAX, zh);
    write_reg(dcf_pkg::REG_ONE_MIN, ol);
    write_reg(dcf_pkg::REG_ONE_MAX, oh);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned               phase_start;
    logic [dcf_pkg::CFG_W-1:0] zl;
    logic [dcf_pkg::CFG_W-1:0] zh;
    logic [dcf_pkg::CFG_W-1:0] ol;
    logic [dcf_pkg::CFG_W-1:0] oh;
    logic [dcf_pkg::CFG_W-1:0] gl;
    logic [dcf_pkg::CFG_W-1:0] gh;
    logic [dcf_pkg::CFG_W-1:0] sl;
    logic [dcf_pkg::CFG_W-1:0] sh;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks on the reset thresholds: restarts, ignored edges,
    // invalid pulses, fail clear alone and together with a fault
    send_sample(1'b0, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);

    // Flood short pulses so the fault total wraps
    no_idle = 1'b1;
    repeat (260) begin
      send_sample(1'b1, 1'b0, 1'b0);
      send_sample(1'b0, 1'b0, 1'b0);
    end
    no_idle = 1'b0;

    // Random frames and noise over several threshold sets
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: load_thresholds(16'd0, 16'd1, 16'd3, 16'd4, 16'd0, 16'd0, 16'd1, 16'd1);
        1: begin
          zl = dcf_pkg::CFG_W'($urandom_range(0, 1));
          zh = zl + dcf_pkg::CFG_W'($urandom_range(0, 1));
          ol = zh + dcf_pkg::CFG_W'(1);
          oh = ol + dcf_pkg::CFG_W'($urandom_range(0, 1));
          gl = dcf_pkg::CFG_W'($urandom_range(1, 2));
          gh = gl + dcf_pkg::CFG_W'($urandom_range(0, 1));
          sl = gh + dcf_pkg::CFG_W'(1 + $urandom_range(0, 1));
          sh = sl + dcf_pkg::CFG_W'($urandom_range(0, 1));
          load_thresholds(gl, gh, sl, sh, zl, zh, ol, oh);
          // long result hold while the sender keeps going
          hold_request = 1'b1;
        end
        // wide windows, zero and one overlapping
        2: load_thresholds(16'd0, 16'hFFFF, 16'd3, 16'hFFFF, 16'd0, 16'd2, 16'd1, 16'hFFFF);
        // zero window inverted, sync window a single count
        default: load_thresholds(16'd2, 16'd3, 16'd5, 16'd5, 16'hFFFF, 16'd0, 16'd0, 16'd3);
      endcase
      phase_start = sent;
      while (sent - phase_start < PHASE_ITEMS) begin
        no_idle = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) != 0) send_frame();
        else send_noise();
      end
      no_idle = 1'b0;
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.tick_outcomes.size() == 0) begin
      $display("[dcf77_pulse_receiver_unit] OK");
    end else begin
      $display("[dcf77_pulse_receiver_unit] ERROR");
    end
    $finish;
  end
endmodule
